FILE: rtl/uv_sphere_mesh_generator_top_defines.svh
// Assertion macros for the UV-sphere tessellator.
`ifndef UV_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define UVSPH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvsph: assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define UVSPH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvsph: assertion failed");
`else
`define UVSPH_ASSERT_NOW(lbl, ante, cons)
`define UVSPH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/uvsph_pkg.sv
// Shared types, constants and helper functions of the UV-sphere tessellator.
package uvsph_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [1:0] MODE_VERTEX  = 2'd0;
  localparam logic [1:0] MODE_CAP     = 2'd1;
  localparam logic [1:0] MODE_BAND    = 2'd2;
  localparam logic [1:0] MODE_ILLEGAL = 2'd3;

  localparam int NUM_W = 9;   // angle numerator (ring or slice)
  localparam int DEN_W = 10;  // angle denominator (2*stacks or slices)
  localparam int DIV_W = 11;  // doubled denominator, divider remainder
  localparam int CW    = 34;  // CORDIC datapath, Q2.30 plus headroom
  localparam int Q14_W = 17;
  localparam int POS_W = 26;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] POS_MAX     = 34'sd33554431;
  localparam logic signed [CW-1:0] POS_MIN     = -34'sd33554432;

  typedef struct packed {
    logic [1:0]  mode;
    logic        bad;
    logic        top;
    logic        bot;
    logic [7:0]  slice;
    logic [7:0]  nxt;
    logic [15:0] prod;
  } ctl_t;

  // atan(2^-i) as a fraction of a 2^32 turn
  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q2.30 to Q1.14, round half up, clamp to +-1.0
  function automatic logic signed [Q14_W-1:0] round_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [Q14_W-1:0] o;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) o = 17'sd16384;
    else if (r < -34'sd16384) o = -17'sd16384;
    else o = r[Q14_W-1:0];
    return o;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [CW-1:0] v);
    logic [POS_W-1:0] o;
    if (v > POS_MAX) o = POS_MAX[POS_W-1:0];
    else if (v < POS_MIN) o = POS_MIN[POS_W-1:0];
    else o = v[POS_W-1:0];
    return o;
  endfunction

endpackage

FILE: rtl/uvsph_ifs.sv
// Request and result channel interfaces.
interface uvsph_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [8:0] ring_index;
  logic [7:0] slice_index;
  modport source (output valid, mode, ring_index, slice_index, input ready);
  modport sink (input valid, mode, ring_index, slice_index, output ready);
endinterface

interface uvsph_res_if;
  logic               valid;
  logic               ready;
  logic               is_index;
  logic signed [25:0] pos_x;
  logic signed [25:0] pos_y;
  logic signed [25:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        vertex_number;
  logic               bad_request;
  logic               last;
  modport source (output valid, is_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  vertex_number, bad_request, last, input ready);
  modport sink (input valid, is_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                vertex_number, bad_request, last, output ready);
endinterface

FILE: rtl/uvsph_div_cell.sv
// One restoring-division step: one quotient bit per cell.
module uvsph_div_cell #(
  parameter int Q_W = 17
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvsph_pkg::DIV_W-1:0] rem_i,
  input  logic [Q_W-1:0]              low_i,
  input  logic [Q_W-1:0]              q_i,
  input  logic [uvsph_pkg::DIV_W-1:0] d_i,
  output logic [uvsph_pkg::DIV_W-1:0] rem_o,
  output logic [Q_W-1:0]              low_o,
  output logic [Q_W-1:0]              q_o,
  output logic [uvsph_pkg::DIV_W-1:0] d_o
);
  logic [uvsph_pkg::DIV_W:0] sh;
  logic [uvsph_pkg::DIV_W:0] diff;
  logic                      ge;

  always_comb begin
    sh   = {rem_i, low_i[Q_W-1]};
    diff = sh - {1'b0, d_i};
    ge   = sh >= {1'b0, d_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[uvsph_pkg::DIV_W-1:0] : sh[uvsph_pkg::DIV_W-1:0];
      low_o <= low_i << 1;
      q_o   <= {q_i[Q_W-2:0], ge};
      d_o   <= d_i;
    end
  end
endmodule

FILE: rtl/uvsph_cordic_cell.sv
// One CORDIC rotation step in Q2.30 with a fixed shift.
module uvsph_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [uvsph_pkg::CW-1:0] x_i,
  input  logic signed [uvsph_pkg::CW-1:0] y_i,
  input  logic signed [uvsph_pkg::CW-1:0] z_i,
  input  logic                            flip_i,
  output logic signed [uvsph_pkg::CW-1:0] x_o,
  output logic signed [uvsph_pkg::CW-1:0] y_o,
  output logic signed [uvsph_pkg::CW-1:0] z_o,
  output logic                            flip_o
);
  logic signed [uvsph_pkg::CW-1:0] xs;
  logic signed [uvsph_pkg::CW-1:0] ys;
  logic signed [uvsph_pkg::CW-1:0] at;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    at = uvsph_pkg::atan_turn(SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[uvsph_pkg::CW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + at;
      end
      flip_o <= flip_i;
    end
  end
endmodule

FILE: rtl/uv_sphere_mesh_generator_top.sv
// UV-sphere tessellator: vertex, cap and band index generation over a cell chain.
// A request passes the prep stage, divider cells, CORDIC cells, round, normal and tail registers.
// Throughput: one vertex request per cycle while results are taken; cap and band requests
// give six results, one per cycle while res.ready is high, and hold the tail until the last.
// The pipeline advances as a whole; a held result stalls it only when its tail is full.
// Synchronous active-high rst: clears valids, result counter and config to defaults.
module uv_sphere_mesh_generator_top #(
  parameter int MAX_DIVISIONS = 256,
  parameter int TRIG_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [uvsph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uvsph_pkg::CFG_W-1:0]     cfg_data,
  uvsph_req_if.sink                       req,
  uvsph_res_if.source                     res
);
`include "uv_sphere_mesh_generator_top_defines.svh"

  // Divider: TRIG_BITS+1 quotient bits; CORDIC: TRIG_BITS rotations.
  localparam int QB = TRIG_BITS + 1;
  localparam int NW = TRIG_BITS + 11;   // rounded dividend width
  localparam int NC = TRIG_BITS;
  localparam int P  = QB + NC;          // stage index after the CORDIC chain
  localparam int NS = P + 3;            // control stages: prep, cells, round, multiply

  // ---------------------------------------------------------------------------
  // Configuration registers, clamped on write
  // ---------------------------------------------------------------------------
  logic [8:0]  num_stacks;
  logic [8:0]  num_slices;
  logic [15:0] sphere_radius;
  logic [8:0]  cfg_low9;

  assign cfg_low9 = cfg_data[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stacks    <= 9'd16;
      num_slices    <= 9'd32;
      sphere_radius <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvsph_pkg::CFG_STACKS: begin
          if (cfg_low9 < 9'd2) num_stacks <= 9'd2;
          else if (int'(cfg_low9) > MAX_DIVISIONS) num_stacks <= 9'(MAX_DIVISIONS);
          else num_stacks <= cfg_low9;
        end
        uvsph_pkg::CFG_SLICES: begin
          if (cfg_low9 == 9'd0) num_slices <= 9'd1;
          else if (int'(cfg_low9) > MAX_DIVISIONS) num_slices <= 9'(MAX_DIVISIONS);
          else num_slices <= cfg_low9;
        end
        uvsph_pkg::CFG_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the chain moves whenever the tail can hand over its item
  // ---------------------------------------------------------------------------
  logic              pipe_en;
  logic              tvld;
  logic              t_last;
  uvsph_pkg::ctl_t   tctl;
  logic [2:0]        cnt;

  assign pipe_en   = !tvld || (res.ready && t_last);
  // no transfer is taken while rst holds the chain empty
  assign req.ready = pipe_en && !rst;

  // ---------------------------------------------------------------------------
  // Prep stage: range check, index product, divider operands
  // ---------------------------------------------------------------------------
  logic [9:0]        ring_p3;
  logic [8:0]        slice_p1;
  logic              in_bad;
  logic [8:0]        fac;
  logic [17:0]       prod_full;
  uvsph_pkg::ctl_t   in_ctl;

  always_comb begin
    ring_p3  = {1'b0, req.ring_index} + 10'd3;
    slice_p1 = {1'b0, req.slice_index} + 9'd1;
    in_bad   = ({1'b0, req.slice_index} >= num_slices) ||
               (req.mode == uvsph_pkg::MODE_ILLEGAL) ||
               (req.mode == uvsph_pkg::MODE_VERTEX && req.ring_index > num_stacks) ||
               (req.mode == uvsph_pkg::MODE_BAND && ring_p3 > {1'b0, num_stacks});
    // first ring offset: cap uses the last inner ring, band its own, vertex ring-1
    unique case (req.mode)
      uvsph_pkg::MODE_CAP:  fac = num_stacks - 9'd1;
      uvsph_pkg::MODE_BAND: fac = req.ring_index;
      default: begin
        if (req.ring_index == num_stacks) fac = num_stacks - 9'd1;
        else fac = req.ring_index - 9'd1;
      end
    endcase
    prod_full    = fac * num_slices;
    in_ctl.mode  = req.mode;
    in_ctl.bad   = in_bad;
    in_ctl.top   = req.ring_index == 9'd0;
    in_ctl.bot   = req.ring_index == num_stacks;
    in_ctl.slice = req.slice_index;
    in_ctl.nxt   = (slice_p1 == num_slices) ? 8'd0 : slice_p1[7:0];
    in_ctl.prod  = prod_full[15:0];
  end

  // control shift line running beside the cells
  uvsph_pkg::ctl_t ctl [NS];
  logic            vld [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (pipe_en) begin
      vld[0] <= req.valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctl[0] <= in_ctl;
      for (int k = 1; k < NS; k++) ctl[k] <= ctl[k-1];
    end
  end

  // lane 0: phi = ring / (2*stacks); lane 1: theta = slice / slices
  logic [uvsph_pkg::NUM_W-1:0] s0_num [2];
  logic [uvsph_pkg::DEN_W-1:0] s0_den [2];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_num[0] <= req.ring_index;
      s0_den[0] <= {num_stacks, 1'b0};
      s0_num[1] <= {1'b0, req.slice_index};
      s0_den[1] <= {1'b0, num_slices};
    end
  end

  // ---------------------------------------------------------------------------
  // Angle divider and CORDIC chains, one per lane
  // ---------------------------------------------------------------------------
  logic [uvsph_pkg::DIV_W-1:0]     drem [2][QB+1];
  logic [QB-1:0]                   dlow [2][QB+1];
  logic [QB-1:0]                   dq   [2][QB+1];
  logic [uvsph_pkg::DIV_W-1:0]     dd   [2][QB+1];
  logic signed [uvsph_pkg::CW-1:0] cx   [2][NC+1];
  logic signed [uvsph_pkg::CW-1:0] cy   [2][NC+1];
  logic signed [uvsph_pkg::CW-1:0] cz   [2][NC+1];
  logic                            cflip[2][NC+1];
  logic signed [uvsph_pkg::Q14_W-1:0] a_sin [2];
  logic signed [uvsph_pkg::Q14_W-1:0] a_cos [2];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [NW-1:0] n_full;
    logic [31:0]   ang;
    logic [31:0]   ang_f;
    logic          fl;
    logic signed [uvsph_pkg::CW-1:0] xe;
    logic signed [uvsph_pkg::CW-1:0] ye;

    // round(num/den * 2^TRIG_BITS) = floor((num<<(TB+1) + den) / (2*den))
    always_comb begin
      n_full = (NW'(s0_num[ln]) << QB) + NW'(s0_den[ln]);
      drem[ln][0] = {1'b0, n_full[NW-1:QB]};
      dlow[ln][0] = n_full[QB-1:0];
      dq[ln][0]   = '0;
      dd[ln][0]   = {s0_den[ln], 1'b0};
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
      uvsph_div_cell #(.Q_W(QB)) u_div (
        .clk   (clk),
        .en    (pipe_en),
        .rem_i (drem[ln][j]),
        .low_i (dlow[ln][j]),
        .q_i   (dq[ln][j]),
        .d_i   (dd[ln][j]),
        .rem_o (drem[ln][j+1]),
        .low_o (dlow[ln][j+1]),
        .q_o   (dq[ln][j+1]),
        .d_o   (dd[ln][j+1])
      );
    end

    // fold the left half-plane onto the right, undo with a sign flip later
    always_comb begin
      ang          = {dq[ln][QB][TRIG_BITS-1:0], {(32-TRIG_BITS){1'b0}}};
      fl           = ang[31] ^ ang[30];
      ang_f        = fl ? (ang ^ 32'h8000_0000) : ang;
      cx[ln][0]    = uvsph_pkg::CORDIC_GAIN;
      cy[ln][0]    = '0;
      cz[ln][0]    = {{(uvsph_pkg::CW-32){ang_f[31]}}, ang_f};
      cflip[ln][0] = fl;
    end

    for (genvar i = 0; i < NC; i++) begin : g_cor
      uvsph_cordic_cell #(.SHIFT(i)) u_cor (
        .clk    (clk),
        .en     (pipe_en),
        .x_i    (cx[ln][i]),
        .y_i    (cy[ln][i]),
        .z_i    (cz[ln][i]),
        .flip_i (cflip[ln][i]),
        .x_o    (cx[ln][i+1]),
        .y_o    (cy[ln][i+1]),
        .z_o    (cz[ln][i+1]),
        .flip_o (cflip[ln][i+1])
      );
    end

    always_comb begin
      xe = cflip[ln][NC] ? -cx[ln][NC] : cx[ln][NC];
      ye = cflip[ln][NC] ? -cy[ln][NC] : cy[ln][NC];
    end

    // round stage
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        a_sin[ln] <= uvsph_pkg::round_q14(ye);
        a_cos[ln] <= uvsph_pkg::round_q14(xe);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Normal stage: sin(phi) times cos/sin(theta), poles forced exact
  // ---------------------------------------------------------------------------
  logic signed [33:0] mx;
  logic signed [33:0] mz;
  logic signed [33:0] mx_r;
  logic signed [33:0] mz_r;
  logic signed [15:0] bnx;
  logic signed [15:0] bny;
  logic signed [15:0] bnz;

  always_comb begin
    mx   = a_sin[0] * a_cos[1];
    mz   = a_sin[0] * a_sin[1];
    mx_r = (mx + 34'sd8192) >>> 14;
    mz_r = (mz + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (ctl[P+1].top || ctl[P+1].bot) begin
        bnx <= '0;
        bnz <= '0;
        bny <= ctl[P+1].top ? 16'sd16384 : -16'sd16384;
      end else begin
        bnx <= mx_r[15:0];
        bnz <= mz_r[15:0];
        bny <= a_cos[0][15:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tail: position scaling, then one result per transfer
  // ---------------------------------------------------------------------------
  logic signed [33:0] px;
  logic signed [33:0] py;
  logic signed [33:0] pz;
  logic signed [16:0] rad_s;
  logic [25:0]        tpx;
  logic [25:0]        tpy;
  logic [25:0]        tpz;
  logic signed [15:0] tnx;
  logic signed [15:0] tny;
  logic signed [15:0] tnz;

  // products are formed at the full 34-bit width of the target
  always_comb begin
    rad_s = $signed({1'b0, sphere_radius});
    px    = rad_s * bnx;
    py    = rad_s * bny;
    pz    = rad_s * bnz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvld <= 1'b0;
      cnt  <= 3'd0;
    end else if (pipe_en) begin
      tvld <= vld[P+2];
      cnt  <= 3'd0;
    end else if (res.ready) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tctl <= ctl[P+2];
      tpx  <= uvsph_pkg::sat_pos(px);
      tpy  <= uvsph_pkg::sat_pos(py);
      tpz  <= uvsph_pkg::sat_pos(pz);
      tnx  <= bnx;
      tny  <= bny;
      tnz  <= bnz;
    end
  end

  logic        t_vert;
  logic        t_idx;
  logic [15:0] s16;
  logic [15:0] n16;
  logic [15:0] sl16;
  logic [15:0] r0;
  logic [15:0] base;
  logic [15:0] vnum;

  always_comb begin
    t_vert = !tctl.bad && tctl.mode == uvsph_pkg::MODE_VERTEX;
    t_idx  = !tctl.bad && tctl.mode != uvsph_pkg::MODE_VERTEX;
    t_last = !t_idx || cnt == 3'd5;
    s16    = {8'd0, tctl.slice};
    n16    = {8'd0, tctl.nxt};
    sl16   = {7'd0, num_slices};
    r0     = tctl.prod + 16'd1;
    base   = r0 - sl16;
    vnum   = '0;
    if (tctl.bad) begin
      vnum = '0;
    end else if (tctl.mode == uvsph_pkg::MODE_VERTEX) begin
      if (tctl.top) vnum = '0;
      else if (tctl.bot) vnum = r0;
      else vnum = r0 + s16;
    end else if (tctl.mode == uvsph_pkg::MODE_CAP) begin
      // top fan then bottom fan of this slice
      case (cnt)
        3'd0: vnum = '0;
        3'd1: vnum = s16 + 16'd1;
        3'd2: vnum = n16 + 16'd1;
        3'd3: vnum = r0;
        3'd4: vnum = base + s16;
        3'd5: vnum = base + n16;
        default: vnum = '0;
      endcase
    end else begin
      // quad a b c / c d a
      case (cnt)
        3'd0, 3'd5: vnum = r0 + s16;
        3'd1:       vnum = r0 + n16;
        3'd2, 3'd3: vnum = r0 + sl16 + n16;
        3'd4:       vnum = r0 + sl16 + s16;
        default:    vnum = '0;
      endcase
    end
  end

  assign res.valid         = tvld;
  assign res.is_index      = t_idx;
  assign res.pos_x         = t_vert ? tpx : '0;
  assign res.pos_y         = t_vert ? tpy : '0;
  assign res.pos_z         = t_vert ? tpz : '0;
  assign res.norm_x        = t_vert ? tnx : '0;
  assign res.norm_y        = t_vert ? tny : '0;
  assign res.norm_z        = t_vert ? tnz : '0;
  assign res.vertex_number = vnum;
  assign res.bad_request   = tctl.bad;
  assign res.last          = t_last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `UVSPH_ASSERT_NOW(a_cfg_clamped, 1'b1, num_stacks >= 9'd2 && num_slices != 9'd0)
  `UVSPH_ASSERT_NEXT(a_req_enters, req.valid && req.ready, vld[0])
  `UVSPH_ASSERT_NEXT(a_tail_holds, tvld && !pipe_en, tvld && $stable(tctl))
  `UVSPH_ASSERT_NOW(a_cnt_range, tvld, cnt <= 3'd5)

endmodule

FILE: tb/uv_sphere_mesh_generator_top_tb.sv
// Self-checking testbench for the UV-sphere tessellator top level.
`timescale 1ns / 1ps
module uv_sphere_mesh_generator_top_tb;

  localparam int MAX_DIV   = 256;
  localparam int TRIG_B    = 16;
  localparam int LATENCY   = 2 * TRIG_B + 5;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic        is_index;
    logic [25:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [15:0] vnum;
    logic        bad;
    logic        last;
  } mesh_res_t;

  // Sender and receiver idle modes
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [uvsph_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [uvsph_pkg::CFG_W-1:0] cfg_data;

  uvsph_req_if req ();
  uvsph_res_if res ();

  uv_sphere_mesh_generator_top #(.MAX_DIVISIONS(MAX_DIV), .TRIG_BITS(TRIG_B)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .res(res.source)
  );

  // Predictor copy of the configuration
  int unsigned stacks_q, slices_q, radius_q;

  mesh_res_t expected_mesh[$];
  int mismatches;
  int results_seen;
  int items_sent;
  int vertex_items, cap_items, band_items, bad_items;
  longint cycle_count;
  idle_mode_t idle_mode;
  int hold_off_cycles;  // long receiver hold-off, counted by its own process

  initial forever #5 clk = ~clk;

  // Run guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_to_q14(longint v);
    longint r;
    r = asr(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // Sine and cosine for an angle in a 2^32 turn, in Q1.14
  task automatic rotate_angle(input logic [31:0] ang, output longint sn, output longint cs);
    bit flip;
    longint x, y, z, xs, ys;
    int iters;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    iters = (TRIG_B < 24) ? TRIG_B : 24;
    if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
      ang = ang ^ 32'h8000_0000;
      flip = 1'b1;
    end
    z = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
    for (int i = 0; i < iters; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = q30_to_q14(y);
    cs = q30_to_q14(x);
  endtask

  function automatic logic [31:0] angle_code(longint unsigned num, longint unsigned den);
    longint unsigned code;
    code = ((num << (TRIG_B + 1)) + den) / (2 * den);
    code &= (64'd1 << TRIG_B) - 1;
    return 32'((code << (32 - TRIG_B)) & 64'hFFFF_FFFF);
  endfunction

  function automatic logic [25:0] clip_pos(longint v);
    if (v > 33554431) v = 33554431;
    if (v < -33554432) v = -33554432;
    return v[25:0];
  endfunction

  function automatic longint mul14(longint a, longint b);
    return asr(a * b + 8192, 14);
  endfunction

  function automatic mesh_res_t index_res(int unsigned idx, bit lst);
    mesh_res_t r;
    r = '{default: '0};
    r.is_index = 1'b1;
    r.vnum = idx[15:0];
    r.last = lst;
    return r;
  endfunction

  // Append one expected result to the scoreboard
  task automatic queue_expected(input mesh_res_t r);
    expected_mesh = {expected_mesh, r};
  endtask

  task automatic predict_mesh(input logic [1:0] mode, input int unsigned ring,
                              input int unsigned slice);
    mesh_res_t r;
    int unsigned st, sl, nxt, vn, bottom, base, r0, r1;
    longint nx, ny, nz, sp, cp, sth, cth;
    st = stacks_q;
    sl = slices_q;
    nxt = (slice + 1) % sl;
    r = '{default: '0};
    if (slice >= sl || mode == uvsph_pkg::MODE_ILLEGAL ||
        (mode == uvsph_pkg::MODE_VERTEX && ring > st) ||
        (mode == uvsph_pkg::MODE_BAND && ring + 3 > st)) begin
      r.bad = 1'b1;
      r.last = 1'b1;
      queue_expected(r);
      bad_items++;
    end else if (mode == uvsph_pkg::MODE_VERTEX) begin
      nx = 0;
      nz = 0;
      if (ring == 0) begin
        ny = 16384; vn = 0;
      end else if (ring == st) begin
        ny = -16384; vn = (st - 1) * sl + 1;
      end else begin
        rotate_angle(angle_code(ring, 2 * st), sp, cp);
        rotate_angle(angle_code(slice, sl), sth, cth);
        nx = mul14(sp, cth);
        ny = cp;
        nz = mul14(sp, sth);
        vn = 1 + (ring - 1) * sl + slice;
      end
      r.px = clip_pos(longint'(radius_q) * nx);
      r.py = clip_pos(longint'(radius_q) * ny);
      r.pz = clip_pos(longint'(radius_q) * nz);
      r.nx = nx[15:0];
      r.ny = ny[15:0];
      r.nz = nz[15:0];
      r.vnum = vn[15:0];
      r.last = 1'b1;
      queue_expected(r);
      vertex_items++;
    end else if (mode == uvsph_pkg::MODE_CAP) begin
      bottom = (st - 1) * sl + 1;
      base = sl * (st - 2) + 1;
      queue_expected(index_res(0, 0));
      queue_expected(index_res(slice + 1, 0));
      queue_expected(index_res(nxt + 1, 0));
      queue_expected(index_res(bottom, 0));
      queue_expected(index_res(base + slice, 0));
      queue_expected(index_res(base + nxt, 1));
      cap_items++;
    end else begin
      r0 = ring * sl + 1;
      r1 = r0 + sl;
      queue_expected(index_res(r0 + slice, 0));
      queue_expected(index_res(r0 + nxt, 0));
      queue_expected(index_res(r1 + nxt, 0));
      queue_expected(index_res(r1 + nxt, 0));
      queue_expected(index_res(r1 + slice, 0));
      queue_expected(index_res(r0 + slice, 1));
      band_items++;
    end
  endtask

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------
  function automatic bit send_gap();
    return (idle_mode == IDLE_SEND && $urandom_range(99) < 71) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 6);
  endfunction

  // Offer one request and hold it until the transfer; valid stays high
  // across back-to-back items, so it is never lowered and raised in one step
  task automatic send_request(input logic [1:0] mode, input logic [8:0] ring,
                              input logic [7:0] slice);
    while (send_gap()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.ring_index <= ring;
    req.slice_index <= slice;
    predict_mesh(mode, ring, slice);
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic drop_valid();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block drained and quiet
  task automatic write_reg(input logic [uvsph_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    int unsigned v;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[uvsph_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    v = value & 16'hFFFF;
    if (idx == uvsph_pkg::CFG_STACKS) begin
      v &= 9'h1FF;
      stacks_q = (v < 2) ? 2 : (v > MAX_DIV) ? MAX_DIV : v;
    end else if (idx == uvsph_pkg::CFG_SLICES) begin
      v &= 9'h1FF;
      slices_q = (v < 1) ? 1 : (v > MAX_DIV) ? MAX_DIV : v;
    end else if (idx == uvsph_pkg::CFG_RADIUS) begin
      radius_q = v;
    end
  endtask

  task automatic drain();
    drop_valid();
    while (expected_mesh.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_shape(input int unsigned st, input int unsigned sl,
                           input int unsigned rad);
    drain();
    write_reg(uvsph_pkg::CFG_STACKS, st);
    write_reg(uvsph_pkg::CFG_SLICES, sl);
    write_reg(uvsph_pkg::CFG_RADIUS, rad);
  endtask

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  initial begin
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) check_result();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res.ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV) res.ready <= ($urandom_range(99) >= 71);
      else if (idle_mode == IDLE_BOTH) res.ready <= ($urandom_range(99) >= 6);
      else res.ready <= 1'b1;
    end
  end

  task automatic check_result();
    mesh_res_t e;
    results_seen++;
    if (expected_mesh.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
      return;
    end
    e = expected_mesh.pop_front();
    if (res.is_index !== e.is_index || res.pos_x !== e.px || res.pos_y !== e.py ||
        res.pos_z !== e.pz || res.norm_x !== e.nx || res.norm_y !== e.ny ||
        res.norm_z !== e.nz || res.vertex_number !== e.vnum ||
        res.bad_request !== e.bad || res.last !== e.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %0d at cycle %0d (st %0d sl %0d rad %0d)", mismatches,
                 cycle_count, stacks_q, slices_q, radius_q);
        $display("  exp idx %0b pos %0d %0d %0d nrm %0d %0d %0d vn %0d bad %0b last %0b",
                 e.is_index, $signed(e.px), $signed(e.py), $signed(e.pz), $signed(e.nx),
                 $signed(e.ny), $signed(e.nz), e.vnum, e.bad, e.last);
        $display("  got idx %0b pos %0d %0d %0d nrm %0d %0d %0d vn %0d bad %0b last %0b",
                 res.is_index, res.pos_x, res.pos_y, res.pos_z, res.norm_x, res.norm_y,
                 res.norm_z, res.vertex_number, res.bad_request, res.last);
      end
    end
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    idle_mode = IDLE_NONE;
    // Poles, top and bottom, and a mid-sphere vertex at reset shape
    send_request(uvsph_pkg::MODE_VERTEX, 9'd0, 8'd0);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd16, 8'd31);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd8, 8'd5);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd17, 8'd0);       // ring past bottom pole
    send_request(uvsph_pkg::MODE_VERTEX, 9'd1, 8'd32);       // slice out of range
    send_request(uvsph_pkg::MODE_VERTEX, 9'h1FF, 8'hFF);
    send_request(uvsph_pkg::MODE_CAP, 9'd0, 8'd0);
    send_request(uvsph_pkg::MODE_CAP, 9'h1FF, 8'd31);        // ring ignored, slice wraps
    send_request(uvsph_pkg::MODE_BAND, 9'd0, 8'd31);
    send_request(uvsph_pkg::MODE_BAND, 9'd13, 8'd7);         // last legal band
    send_request(uvsph_pkg::MODE_BAND, 9'd14, 8'd0);         // band past range
    send_request(uvsph_pkg::MODE_ILLEGAL, 9'd3, 8'd3);
    // Extremes: largest shape, radii that clip the position, no radius
    set_shape(256, 256, 16'hFFFF);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd256, 8'd255);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd128, 8'd64);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd37, 8'd200);     // large vertex index
    send_request(uvsph_pkg::MODE_CAP, 9'd0, 8'd255);
    send_request(uvsph_pkg::MODE_BAND, 9'd253, 8'd255);
    set_shape(1, 0, 0);                                      // clamps up to 2 and 1
    send_request(uvsph_pkg::MODE_VERTEX, 9'd1, 8'd0);
    send_request(uvsph_pkg::MODE_CAP, 9'd0, 8'd0);
    send_request(uvsph_pkg::MODE_BAND, 9'd0, 8'd0);
    set_shape(9'h1FF, 9'h1FF, 16'h0800);                     // clamps down to 256
    send_request(uvsph_pkg::MODE_VERTEX, 9'd64, 8'd128);
    send_request(uvsph_pkg::MODE_VERTEX, 9'd200, 8'd17);
  endtask

  task automatic test_random(input int count, input idle_mode_t im);
    logic [1:0] m;
    logic [8:0] ring;
    logic [7:0] slice;
    idle_mode = im;
    for (int n = 0; n < count; n++) begin
      m = 2'($urandom_range(9) < 6 ? 0 : $urandom_range(9) < 8 ? $urandom_range(1, 2) : 3);
      if ($urandom_range(9) == 0) begin
        ring = 9'($urandom());
        slice = 8'($urandom());
      end else begin
        ring = 9'($urandom_range(m == uvsph_pkg::MODE_BAND ? stacks_q - 2 : stacks_q));
        slice = 8'($urandom_range(slices_q - 1));
      end
      send_request(m, ring, slice);
    end
  endtask

  // Receiver holds off while requests keep coming, to fill the pipeline
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    hold_off_cycles = 300;
    for (int n = 0; n < 40; n++)
      send_request(2'($urandom_range(2)), 9'($urandom_range(stacks_q - 2)),
                   8'($urandom_range(slices_q - 1)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.mode = '0;
    req.ring_index = '0;
    req.slice_index = '0;
    stacks_q = 16;
    slices_q = 32;
    radius_q = 256;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    vertex_items = 0;
    cap_items = 0;
    band_items = 0;
    bad_items = 0;
    hold_off_cycles = 0;
    idle_mode = IDLE_NONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    set_shape(16, 32, 256);
    test_random(80, IDLE_NONE);
    set_shape($urandom_range(2, 40), $urandom_range(1, 64), $urandom_range(0, 2047));
    test_random(80, IDLE_SEND);
    set_shape($urandom_range(3, 256), $urandom_range(1, 256), $urandom_range(0, 65535));
    test_random(80, IDLE_RECV);
    set_shape($urandom_range(2, 64), $urandom_range(1, 256), $urandom_range(0, 4095));
    test_random(80, IDLE_BOTH);
    test_backpressure();
    drain();

    $display("covered %0d requests: %0d vertex, %0d cap, %0d band, %0d rejected",
             items_sent, vertex_items, cap_items, band_items, bad_items);
    $display("checked %0d results over several shapes and idle patterns", results_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
